// ===== src/lcdfb_pkg.sv =====
package lcdfb_pkg;

  // Default geometry of the display.
  localparam int DEF_COLUMNS    = 128;
  localparam int DEF_PAGES      = 8;
  localparam int DEF_BLOCK_SIZE = 5;

  // Opcodes of an input beat.
  localparam logic [2:0] OP_PIXEL    = 3'd0;
  localparam logic [2:0] OP_BLOCK    = 3'd1;
  localparam logic [2:0] OP_CLEAR    = 3'd2;
  localparam logic [2:0] OP_CONTRAST = 3'd3;
  localparam logic [2:0] OP_REFRESH  = 3'd4;

  // Controller command bytes.
  localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
  localparam logic [7:0] CMD_COL_LO     = 8'h00;
  localparam logic [7:0] CMD_COL_HI     = 8'h10;
  localparam logic [7:0] CMD_VOLUME     = 8'h81;
  localparam logic [7:0] CMD_RATIO_BASE = 8'h20;
  localparam logic [7:0] RATIO_MAX      = 8'd7;
  localparam logic [7:0] LEVEL_MAX      = 8'd63;

  // Number of command beats that open each page of a refresh.
  localparam int REF_CMD_BEATS = 3;

  // Logical row to physical row, indexed by an 8-bit logical row.
  typedef logic [255:0][6:0] row_tbl_t;

  // Builds the remap table (v + rows/2 - 1) mod rows with a wrapping counter.
  function automatic row_tbl_t make_row_table(input int rows);
    row_tbl_t tbl;
    int       r;
    r = (rows >> 1) - 1;
    for (int v = 0; v < 256; v++) begin
      tbl[v] = 7'(r);
      if (r == rows - 1) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return tbl;
  endfunction

  typedef struct packed {
    logic cap;
    logic clr_wr;
    logic pix_rd;
    logic pix_wr;
    logic pix_adv;
    logic ref_rd;
    logic emit_con;
    logic emit_ref;
  } lcdfb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pix_skip;
    logic pix_last;
    logic con_last;
    logic out_free;
  } lcdfb_sts_t;

endpackage

// ===== src/lcdfb_ctrl.sv =====
module lcdfb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [2:0]            in_opcode,
  input  lcdfb_pkg::lcdfb_sts_t sts,
  output logic                  in_stall,
  output lcdfb_pkg::lcdfb_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_CON,
    ST_REF_RD,
    ST_REF_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          case (in_opcode)
            lcdfb_pkg::OP_PIXEL:    state_nxt = ST_PIX_RD;
            lcdfb_pkg::OP_BLOCK:    state_nxt = ST_PIX_RD;
            lcdfb_pkg::OP_CLEAR:    state_nxt = ST_CLR;
            lcdfb_pkg::OP_CONTRAST: state_nxt = ST_CON;
            lcdfb_pkg::OP_REFRESH:  state_nxt = ST_REF_RD;
            default:                state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PIX_RD: begin
        if (sts.pix_skip) begin
          cmd.pix_adv = 1'b1;
          if (sts.pix_last) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.pix_rd = 1'b1;
          state_nxt  = ST_PIX_WR;
        end
      end
      ST_PIX_WR: begin
        cmd.pix_wr  = 1'b1;
        cmd.pix_adv = 1'b1;
        state_nxt   = sts.pix_last ? ST_IDLE : ST_PIX_RD;
      end
      ST_CON: begin
        if (sts.out_free) begin
          cmd.emit_con = 1'b1;
          if (sts.con_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REF_RD: begin
        cmd.ref_rd = 1'b1;
        state_nxt  = ST_REF_EMIT;
      end
      ST_REF_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_ref = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/lcdfb_dpath.sv =====
module lcdfb_dpath #(
  parameter int COLUMNS    = lcdfb_pkg::DEF_COLUMNS,
  parameter int PAGES      = lcdfb_pkg::DEF_PAGES,
  parameter int BLOCK_SIZE = lcdfb_pkg::DEF_BLOCK_SIZE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcdfb_pkg::lcdfb_cmd_t cmd,
  output lcdfb_pkg::lcdfb_sts_t sts,
  input  logic [2:0]            in_opcode,
  input  logic [6:0]            in_x_pos,
  input  logic [6:0]            in_y_pos,
  input  logic                  in_colour,
  input  logic [7:0]            in_resistor_ratio,
  input  logic [7:0]            in_contrast_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_is_data,
  output logic                  out_last,
  output logic                  out_frame_end
);

  localparam int ROWS        = PAGES * 8;
  localparam int STORE_DEPTH = PAGES * COLUMNS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int POS_W       = $clog2(COLUMNS + lcdfb_pkg::REF_CMD_BEATS);
  localparam int BLK_W       = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam lcdfb_pkg::row_tbl_t ROW_TBL = lcdfb_pkg::make_row_table(ROWS);

  logic [7:0]        frame_mem_r [STORE_DEPTH];
  logic [7:0]        rdata_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic [6:0]        x_r, y_r;
  logic              colour_r, single_r;
  logic [7:0]        ratio_r, level_r;
  logic [BLK_W-1:0]  bi_r, bj_r;
  logic [1:0]        con_idx_r;

  logic [PAGE_W-1:0] ref_page_r;
  logic [POS_W-1:0]  ref_pos_r;
  logic [ADDR_W-1:0] ref_addr_r;

  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_is_data_r, out_last_r, out_frame_end_r;

  // Pixel address of the current block position.
  logic [7:0]        pix_x, pix_y;
  logic [6:0]        pix_row;
  logic [3:0]        pix_page;
  logic [ADDR_W-1:0] pix_addr, rd_addr;
  logic [7:0]        pix_mask, pix_wdata;
  logic              bi_end, bj_end;

  assign pix_x    = {1'b0, x_r} + 8'(bi_r);
  assign pix_y    = {1'b0, y_r} + 8'(bj_r);
  assign pix_row  = ROW_TBL[pix_y];
  assign pix_page = pix_row[6:3];
  assign pix_addr = ADDR_W'(32'(pix_page) * COLUMNS + 32'(pix_x));
  assign pix_mask = 8'b1 << pix_row[2:0];
  assign pix_wdata = colour_r ? (rdata_r | pix_mask) : (rdata_r & ~pix_mask);
  assign bi_end   = (bi_r == BLK_W'(BLOCK_SIZE - 1));
  assign bj_end   = (bj_r == BLK_W'(BLOCK_SIZE - 1));
  assign rd_addr  = cmd.ref_rd ? ref_addr_r : pix_addr;

  // Refresh stream decode.
  logic       ref_is_data, page_done, frame_done;
  logic [7:0] ref_byte, ratio_c, level_c, con_byte;

  assign ref_is_data = (ref_pos_r >= POS_W'(lcdfb_pkg::REF_CMD_BEATS));
  assign page_done   = (ref_pos_r == POS_W'(COLUMNS + lcdfb_pkg::REF_CMD_BEATS - 1));
  assign frame_done  = page_done && (ref_page_r == PAGE_W'(PAGES - 1));
  assign ratio_c     = (ratio_r > lcdfb_pkg::RATIO_MAX) ? lcdfb_pkg::RATIO_MAX : ratio_r;
  assign level_c     = (level_r > lcdfb_pkg::LEVEL_MAX) ? lcdfb_pkg::LEVEL_MAX : level_r;

  always_comb begin
    case (ref_pos_r)
      POS_W'(0): ref_byte = lcdfb_pkg::CMD_PAGE_BASE | 8'(ref_page_r);
      POS_W'(1): ref_byte = lcdfb_pkg::CMD_COL_LO;
      POS_W'(2): ref_byte = lcdfb_pkg::CMD_COL_HI;
      default:   ref_byte = rdata_r;
    endcase
    case (con_idx_r)
      2'd0:    con_byte = lcdfb_pkg::CMD_RATIO_BASE | ratio_c;
      2'd1:    con_byte = lcdfb_pkg::CMD_VOLUME;
      default: con_byte = level_c;
    endcase
  end

  assign sts.clr_last = (clr_addr_r == ADDR_W'(STORE_DEPTH - 1));
  assign sts.pix_skip = ({1'b0, pix_x} >= 9'(COLUMNS)) ||
                        (!single_r && ({1'b0, pix_y} > 9'(ROWS)));
  assign sts.pix_last = single_r || (bi_end && bj_end);
  assign sts.con_last = (con_idx_r == 2'd2);
  assign sts.out_free = !out_valid_r || !out_stall;

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      frame_mem_r[clr_addr_r] <= 8'd0;
    end else if (cmd.pix_wr) begin
      frame_mem_r[pix_addr] <= pix_wdata;
    end
    if (cmd.pix_rd || cmd.ref_rd) begin
      rdata_r <= frame_mem_r[rd_addr];
    end
  end

  // Captured item fields and the output beat fields.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      x_r      <= in_x_pos;
      y_r      <= in_y_pos;
      colour_r <= in_colour;
      ratio_r  <= in_resistor_ratio;
      level_r  <= in_contrast_level;
      single_r <= (in_opcode == lcdfb_pkg::OP_PIXEL);
    end
    if (cmd.emit_con || cmd.emit_ref) begin
      out_byte_r      <= cmd.emit_ref ? ref_byte : con_byte;
      out_is_data_r   <= cmd.emit_ref && ref_is_data;
      out_last_r      <= cmd.emit_ref || sts.con_last;
      out_frame_end_r <= cmd.emit_ref && frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      bi_r        <= '0;
      bj_r        <= '0;
      con_idx_r   <= '0;
      ref_page_r  <= '0;
      ref_pos_r   <= '0;
      ref_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr_r <= sts.clr_last ? '0 : clr_addr_r + 1'b1;
      end
      if (cmd.cap) begin
        bi_r      <= '0;
        bj_r      <= '0;
        con_idx_r <= '0;
      end else begin
        if (cmd.pix_adv) begin
          if (bj_end) begin
            bj_r <= '0;
            bi_r <= bi_r + 1'b1;
          end else begin
            bj_r <= bj_r + 1'b1;
          end
        end
        if (cmd.emit_con) begin
          con_idx_r <= con_idx_r + 2'd1;
        end
      end
      if (cmd.emit_ref) begin
        if (ref_is_data) begin
          ref_addr_r <= frame_done ? '0 : ref_addr_r + 1'b1;
        end
        if (page_done) begin
          ref_pos_r  <= '0;
          ref_page_r <= frame_done ? '0 : ref_page_r + 1'b1;
        end else begin
          ref_pos_r <= ref_pos_r + 1'b1;
        end
      end
      if (cmd.emit_con || cmd.emit_ref) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_is_data   = out_is_data_r;
  assign out_last      = out_last_r;
  assign out_frame_end = out_frame_end_r;

endmodule

// ===== src/lcd_page_framebuffer_writer.sv =====
// Pixel write: one store read-modify-write; block write: up to BLOCK_SIZE^2 of them.
// Clear: zeroes all PAGES*COLUMNS store bytes, one store byte per cycle through the single write port.
// Contrast: three beats, one per cycle while the output register is free.
// Refresh step: one beat, emitted from ST_REF_EMIT after the registered store read in ST_REF_RD.
// Reset: synchronous, active low; a clearing pass over the PAGES*COLUMNS store bytes
// (1024 by default) zeroes the frame store while in_stall is held high.
module lcd_page_framebuffer_writer #(
  parameter int COLUMNS    = lcdfb_pkg::DEF_COLUMNS,
  parameter int PAGES      = lcdfb_pkg::DEF_PAGES,
  parameter int BLOCK_SIZE = lcdfb_pkg::DEF_BLOCK_SIZE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_opcode,
  input  logic [6:0] in_x_pos,
  input  logic [6:0] in_y_pos,
  input  logic       in_colour,
  input  logic [7:0] in_resistor_ratio,
  input  logic [7:0] in_contrast_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_last,
  output logic       out_frame_end
);

  // The controller accepts one beat at a time and sequences the datapath through
  // store sweeps, read-modify-write pixel updates and output beats. The output
  // register lets a new beat be accepted while the previous result still waits.
  lcdfb_pkg::lcdfb_cmd_t cmd;
  lcdfb_pkg::lcdfb_sts_t sts;

  lcdfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // The datapath owns the frame store, the block walk counters, the refresh
  // stream position and the output register.
  lcdfb_dpath #(
    .COLUMNS    (COLUMNS),
    .PAGES      (PAGES),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_opcode),
    .in_x_pos          (in_x_pos),
    .in_y_pos          (in_y_pos),
    .in_colour         (in_colour),
    .in_resistor_ratio (in_resistor_ratio),
    .in_contrast_level (in_contrast_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_is_data       (out_is_data),
    .out_last          (out_last),
    .out_frame_end     (out_frame_end)
  );

endmodule

// ===== test/tb_lcd_page_framebuffer_writer.sv =====
module tb_lcd_page_framebuffer_writer;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the block under test. It is built with the package defaults.
  localparam int COLS            = lcdfb_pkg::DEF_COLUMNS;
  localparam int PAGE_COUNT      = lcdfb_pkg::DEF_PAGES;
  localparam int SQUARE          = lcdfb_pkg::DEF_BLOCK_SIZE;
  localparam int ROWS            = PAGE_COUNT * 8;
  localparam int STORE_BYTES     = COLS * PAGE_COUNT;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  // A clear walks the whole store, and so does the pass that follows reset. The
  // long receiver hold-off adds its LONG_HOLD stretch on top. Nothing else comes close.
  localparam int IDLE_LIMIT      = 5000;
  localparam int TAIL_CYCLES     = 40;
  localparam int LONG_HOLD       = 300;
  localparam int RANDOM_BEATS    = 262;

  // One beat on the byte stream toward the display controller.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_data;
    logic       last;
    logic       frame_end;
  } lcd_beat_t;

  // Mirrors the frame store and the refresh scan position, and holds the byte
  // stream that the block still owes.
  class frame_stream_model;
    bit [7:0]    frame_bytes [STORE_BYTES];
    int unsigned scan_page;
    int unsigned scan_pos;
    lcd_beat_t   owed_q [$];
    int          errors;
    int          frames;
    int          beats_checked;
    int          op_count [8];

    function new();
      foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
      foreach (op_count[k]) op_count[k] = 0;
      scan_page     = 0;
      scan_pos      = 0;
      errors        = 0;
      frames        = 0;
      beats_checked = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void owe(logic [7:0] b, logic d, logic l, logic f);
      owed_q.push_back({b, d, l, f});
    endfunction

    // Logical row y lands on physical row (y + ROWS/2 - 1) mod ROWS.
    function void paint(int unsigned x, int unsigned y, bit white);
      int unsigned row;
      int unsigned idx;
      if (x >= COLS) return;
      row = (y + ROWS / 2 - 1) % ROWS;
      idx = (row >> 3) * COLS + x;
      frame_bytes[idx][row & 7] = white;
    endfunction

    function void scan_step();
      int unsigned col;
      bit          page_done;
      bit          frame_done;
      if (scan_pos < lcdfb_pkg::REF_CMD_BEATS) begin
        case (scan_pos)
          0: owe(lcdfb_pkg::CMD_PAGE_BASE | 8'(scan_page), 1'b0, 1'b1, 1'b0);
          1: owe(lcdfb_pkg::CMD_COL_LO, 1'b0, 1'b1, 1'b0);
          default: owe(lcdfb_pkg::CMD_COL_HI, 1'b0, 1'b1, 1'b0);
        endcase
        scan_pos++;
      end else begin
        col        = scan_pos - lcdfb_pkg::REF_CMD_BEATS;
        page_done  = (col == COLS - 1);
        frame_done = page_done && (scan_page == PAGE_COUNT - 1);
        owe(frame_bytes[scan_page * COLS + col], 1'b1, 1'b1, frame_done);
        if (page_done) begin
          scan_pos  = 0;
          scan_page = frame_done ? 0 : scan_page + 1;
          if (frame_done) frames++;
        end else begin
          scan_pos++;
        end
      end
    endfunction

    // Called for every input beat the block accepts.
    function void note_input(logic [2:0] op, logic [6:0] x, logic [6:0] y, logic colour,
                             logic [7:0] ratio, logic [7:0] level);
      int unsigned xi;
      int unsigned yi;
      xi = x;
      yi = y;
      op_count[op]++;
      case (op)
        lcdfb_pkg::OP_PIXEL: paint(xi, yi, colour);
        lcdfb_pkg::OP_BLOCK: begin
          for (int i = 0; i < SQUARE; i++)
            for (int j = 0; j < SQUARE; j++)
              if (yi + j <= ROWS) paint(xi + i, yi + j, colour);
        end
        lcdfb_pkg::OP_CLEAR: foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
        lcdfb_pkg::OP_CONTRAST: begin
          owe(((ratio > lcdfb_pkg::RATIO_MAX) ? lcdfb_pkg::RATIO_MAX : ratio)
              | lcdfb_pkg::CMD_RATIO_BASE, 1'b0, 1'b0, 1'b0);
          owe(lcdfb_pkg::CMD_VOLUME, 1'b0, 1'b0, 1'b0);
          owe((level > lcdfb_pkg::LEVEL_MAX) ? lcdfb_pkg::LEVEL_MAX : level,
              1'b0, 1'b1, 1'b0);
        end
        lcdfb_pkg::OP_REFRESH: scan_step();
        default: ;
      endcase
    endfunction

    // Called for every output beat the testbench accepts.
    function void check_result(lcd_beat_t got);
      lcd_beat_t want;
      bit        bad;
      if (owed_q.size() == 0) begin
        $display("%0t: output beat with nothing pending, expected none, got %p", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      bad  = 1'b0;
      beats_checked++;
      if (got.byte_val !== want.byte_val) begin
        $display("%0t: out_byte mismatch, expected 0x%02h, got 0x%02h",
                 $time, want.byte_val, got.byte_val);
        bad = 1'b1;
      end
      if (got.is_data !== want.is_data) begin
        $display("%0t: out_is_data mismatch, expected %b, got %b",
                 $time, want.is_data, got.is_data);
        bad = 1'b1;
      end
      if (got.last !== want.last) begin
        $display("%0t: out_last mismatch, expected %b, got %b", $time, want.last, got.last);
        bad = 1'b1;
      end
      if (got.frame_end !== want.frame_end) begin
        $display("%0t: out_frame_end mismatch, expected %b, got %b",
                 $time, want.frame_end, got.frame_end);
        bad = 1'b1;
      end
      if (bad) errors++;
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_opcode;
  logic [6:0] in_x_pos;
  logic [6:0] in_y_pos;
  logic       in_colour;
  logic [7:0] in_resistor_ratio;
  logic [7:0] in_contrast_level;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_is_data;
  logic       out_last;
  logic       out_frame_end;

  frame_stream_model model = new();

  // When set, the sender runs without gaps (a burst stretch).
  bit no_gaps   = 1'b0;
  // Raised by the stimulus to ask the result side for one long hold-off.
  bit hold_req  = 1'b0;
  int idle_cycles = 0;

  lcd_page_framebuffer_writer #(
    .COLUMNS    (COLS),
    .PAGES      (PAGE_COUNT),
    .BLOCK_SIZE (SQUARE)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_x_pos          (in_x_pos),
    .in_y_pos          (in_y_pos),
    .in_colour         (in_colour),
    .in_resistor_ratio (in_resistor_ratio),
    .in_contrast_level (in_contrast_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_is_data       (out_is_data),
    .out_last          (out_last),
    .out_frame_end     (out_frame_end)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The random phase spreads over every opcode, the unused ones included, with
  // refresh steps the most common.
  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return lcdfb_pkg::OP_REFRESH;
    if (r < 65) return lcdfb_pkg::OP_PIXEL;
    if (r < 78) return lcdfb_pkg::OP_BLOCK;
    if (r < 88) return lcdfb_pkg::OP_CONTRAST;
    if (r < 91) return lcdfb_pkg::OP_CLEAR;
    return 3'(lcdfb_pkg::OP_REFRESH + $urandom_range(1, 3));
  endfunction

  // Offers one beat and holds it steady until the block takes it. Every call starts
  // and ends at a rising edge, so in_valid sees at most one assignment per step.
  task automatic send_beat(input logic [2:0] op, input logic [6:0] x, input logic [6:0] y,
                           input logic colour, input logic [7:0] ratio,
                           input logic [7:0] level, input int gap);
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_x_pos          <= x;
    in_y_pos          <= y;
    in_colour         <= colour;
    in_resistor_ratio <= ratio;
    in_contrast_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model.note_input(op, x, y, colour, ratio, level);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random payload for one opcode. Rows mostly stay in the nominal 0..ROWS span,
  // but the full 7-bit range is exercised too; ratio and level often sit near
  // their clamp points.
  task automatic send_random(input logic [2:0] op);
    logic [6:0] x;
    logic [6:0] y;
    logic [7:0] ratio;
    logic [7:0] level;
    x     = 7'($urandom_range(0, 127));
    y     = ($urandom_range(0, 99) < 70) ? 7'($urandom_range(0, ROWS))
                                         : 7'($urandom_range(0, 127));
    ratio = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    level = $urandom_range(0, 1) ? 8'($urandom_range(56, 71)) : 8'($urandom_range(0, 255));
    send_beat(op, x, y, 1'($urandom_range(0, 1)), ratio, level, pick_gap());
  endtask

  // Result side: checks every accepted beat and drives out_stall. It alternates
  // runs of free flow with stalls of random length, and on request holds off for
  // a LONG_HOLD stretch so the block backs up into its input.
  initial begin : result_sink
    int run_left;
    int stall_left;
    int hold_left;
    run_left   = 0;
    stall_left = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        model.check_result({out_byte, out_is_data, out_last, out_frame_end});
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(0, 25);
          stall_left = pick_gap();
        end
      end
    end
  end

  // Watchdog: any cycle in which neither channel moves a beat counts toward the
  // limit; a single handshake on either side resets it.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d beats still pending",
               $time, IDLE_LIMIT, model.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int         counted;
    logic [2:0] op;
    counted = 0;

    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_opcode         <= lcdfb_pkg::OP_PIXEL;
    in_x_pos          <= '0;
    in_y_pos          <= '0;
    in_colour         <= 1'b0;
    in_resistor_ratio <= '0;
    in_contrast_level <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears its store after reset with in_stall high; send_beat simply
    // waits that out.

    // Directed part. A fresh scan starts with the three page 0 commands.
    repeat (3) send_beat(lcdfb_pkg::OP_REFRESH, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, pick_gap());
    // Row 33 maps to physical row 0 and row 40 to row 7, both on page 0, so the
    // next two data bytes read back as 0x01 and 0x80.
    send_beat(lcdfb_pkg::OP_PIXEL, 7'd0, 7'd33, 1'b1, 8'd0, 8'd0, pick_gap());
    send_beat(lcdfb_pkg::OP_PIXEL, 7'd1, 7'd40, 1'b1, 8'd0, 8'd0, pick_gap());
    repeat (2) send_beat(lcdfb_pkg::OP_REFRESH, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, pick_gap());
    // Edge rows and columns: the highest nominal logical row, a row beyond it
    // that only the modular remap brings back, and a set followed by a clear.
    send_beat(lcdfb_pkg::OP_PIXEL, 7'd127, 7'(ROWS), 1'b1, 8'd0, 8'd0, pick_gap());
    send_beat(lcdfb_pkg::OP_PIXEL, 7'd2, 7'd127, 1'b1, 8'd0, 8'd0, pick_gap());
    send_beat(lcdfb_pkg::OP_PIXEL, 7'd0, 7'd0, 1'b1, 8'd0, 8'd0, pick_gap());
    send_beat(lcdfb_pkg::OP_PIXEL, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, pick_gap());
    send_beat(lcdfb_pkg::OP_PIXEL, 7'd3, 7'd32, 1'b1, 8'd0, 8'd0, pick_gap());
    // A block in the far corner loses the columns past the right edge and the
    // rows past the last logical row.
    send_beat(lcdfb_pkg::OP_BLOCK, 7'd125, 7'd62, 1'b1, 8'd0, 8'd0, pick_gap());
    // A white block over page 0 columns 2..6, then a black one shifted down by two
    // rows; the scan reads column 2 after the first and column 3 after the second.
    send_beat(lcdfb_pkg::OP_BLOCK, 7'd2, 7'd33, 1'b1, 8'd0, 8'd0, pick_gap());
    send_beat(lcdfb_pkg::OP_REFRESH, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, pick_gap());
    send_beat(lcdfb_pkg::OP_BLOCK, 7'd2, 7'd35, 1'b0, 8'd0, 8'd0, pick_gap());
    send_beat(lcdfb_pkg::OP_REFRESH, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, pick_gap());
    // A block that starts below every valid row writes nothing at all.
    send_beat(lcdfb_pkg::OP_BLOCK, 7'd60, 7'd127, 1'b1, 8'd0, 8'd0, pick_gap());
    // Contrast at both ends of each field and just past the clamp points.
    send_beat(lcdfb_pkg::OP_CONTRAST, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, pick_gap());
    send_beat(lcdfb_pkg::OP_CONTRAST, 7'd0, 7'd0, 1'b0, lcdfb_pkg::RATIO_MAX,
              lcdfb_pkg::LEVEL_MAX, pick_gap());
    send_beat(lcdfb_pkg::OP_CONTRAST, 7'd0, 7'd0, 1'b0, lcdfb_pkg::RATIO_MAX + 8'd1,
              lcdfb_pkg::LEVEL_MAX + 8'd1, pick_gap());
    send_beat(lcdfb_pkg::OP_CONTRAST, 7'd0, 7'd0, 1'b0, 8'hFF, 8'hFF, pick_gap());
    // The three opcodes above the last defined one must pass without any effect.
    for (int k = 1; k <= 3; k++) send_random(3'(lcdfb_pkg::OP_REFRESH + k));
    // After a clear the scan must read back zeros.
    send_beat(lcdfb_pkg::OP_CLEAR, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, pick_gap());
    repeat (2) send_beat(lcdfb_pkg::OP_REFRESH, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, pick_gap());

    // Backpressure: the result side holds off for a long stretch while contrast
    // beats keep arriving with random gaps, so the block has to stall its input.
    hold_req = 1'b1;
    repeat (20) send_random(lcdfb_pkg::OP_CONTRAST);

    // Random part. Bursts without any sender gaps recur every 80 beats.
    while (counted < RANDOM_BEATS) begin
      op      = pick_op();
      no_gaps = (counted % 80) < 20;
      send_random(op);
      counted++;
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    // Drain, then give the block a little more time to show any stray beat.
    while (model.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Input beats: %0d pixel, %0d block, %0d clear, %0d contrast, %0d refresh, %0d unused",
             model.op_count[lcdfb_pkg::OP_PIXEL], model.op_count[lcdfb_pkg::OP_BLOCK],
             model.op_count[lcdfb_pkg::OP_CLEAR], model.op_count[lcdfb_pkg::OP_CONTRAST],
             model.op_count[lcdfb_pkg::OP_REFRESH],
             model.op_count[5] + model.op_count[6] + model.op_count[7]);
    $display("Output beats checked: %0d, full frame scans: %0d, failures: %0d",
             model.beats_checked, model.frames, model.errors);
    if (model.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
